### rtl/core/tmjr_pkg.sv
package tmjr_pkg;

   // Width of the request and response data fields, and width of the z and w lag words.
   localparam int unsigned DATA_W = 32;
   localparam int unsigned LAG_W  = 31;

   // Index width of the shift-subtract iteration count.
   localparam int unsigned ITER_W = $clog2(DATA_W);

   // Generator seeds and the timestamp mixing offset.
   localparam logic [DATA_W-1:0] SEED_Y     = 32'd234567891;
   localparam logic [LAG_W-1:0]  SEED_Z     = 31'd345678912;
   localparam logic [LAG_W-1:0]  SEED_W     = 31'd456789123;
   localparam logic [DATA_W-1:0] MIX_OFFSET = 32'd1411392427;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_SUM,
      ST_DIVIDE,
      ST_FINISH
   } seq_state_type;

   // Status of the remainder unit as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } rem_stat_type;

endpackage

### rtl/core/tmjr_rem_unit.sv
module tmjr_rem_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tmjr_pkg::DATA_W-1:0]  dividend,
   input  logic [tmjr_pkg::DATA_W-1:0]  divisor,
   output tmjr_pkg::rem_stat_type       stat,
   output logic [tmjr_pkg::DATA_W-1:0]  remainder
);
   import tmjr_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] count_ff, count_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] div_ff, div_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;

   // One restoring shift-subtract step per cycle, most significant bit first.
   always_comb begin
      trial    = {rem_ff, quo_ff[DATA_W-1]};
      diff     = trial - {1'b0, div_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         div_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[DATA_W-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
         end else begin
            rem_in = trial[DATA_W-1:0];
         end
         if (count_ff == ITER_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the datapath words need none.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

endmodule

### rtl/core/timestamp_mixed_jkiss32_rng.sv
// A request beat passes through the generator step, the sum, the remainder load, the remainder
// iterations (one per dividend bit), the completion check and the output load; a zero bound
// skips the remainder stages. The radix-2 remainder unit handles one bit per cycle, and the block
// takes no new beat until the last one is loaded out; a held response stalls the next beat.
// Synchronous active-high reset loads the generator seeds and empties the
// response register.
module timestamp_mixed_jkiss32_rng (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [tmjr_pkg::DATA_W-1:0]  req_time_ms,
   input  logic [tmjr_pkg::DATA_W-1:0]  req_max_val,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [tmjr_pkg::DATA_W-1:0]  rsp_raw_value,
   output logic [tmjr_pkg::DATA_W-1:0]  rsp_ranged_value,
   output logic                         rsp_bad_bound
);
   import tmjr_pkg::*;

   seq_state_type     state_ff, state_in;
   logic [DATA_W-1:0] xmix_ff, xmix_in;
   logic [DATA_W-1:0] bound_ff, bound_in;
   logic [DATA_W-1:0] y_ff, y_in;
   logic [LAG_W-1:0]  z_ff, z_in;
   logic [LAG_W-1:0]  w_ff, w_in;
   logic              c_ff, c_in;
   logic [DATA_W-1:0] raw_ff, raw_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_raw_ff, rsp_raw_in;
   logic [DATA_W-1:0] rsp_ranged_ff, rsp_ranged_in;
   logic              rsp_bad_ff, rsp_bad_in;

   logic              req_beat;
   logic              out_load;
   rem_stat_type      rem_stat;
   logic [DATA_W-1:0] rem_value;
   logic [DATA_W-1:0] xs1, xs2, xs3;
   logic [DATA_W-1:0] awc_sum;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat  = req_valid && req_ready;

   // Xorshift 5/7/22 on the y word and 31-bit add-with-carry on z and w.
   always_comb begin
      xs1     = y_ff ^ (y_ff << 5);
      xs2     = xs1 ^ (xs1 >> 7);
      xs3     = xs2 ^ (xs2 << 22);
      awc_sum = {1'b0, z_ff} + {1'b0, w_ff} + {{(DATA_W-1){1'b0}}, c_ff};
   end

   // Sequencer: next state and datapath loads.
   always_comb begin
      state_in  = state_ff;
      xmix_in   = xmix_ff;
      bound_in  = bound_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      w_in      = w_ff;
      c_in      = c_ff;
      raw_in    = raw_ff;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               xmix_in  = req_time_ms + MIX_OFFSET;
               bound_in = req_max_val;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            y_in     = xs3;
            z_in     = w_ff;
            c_in     = awc_sum[DATA_W-1];
            w_in     = awc_sum[LAG_W-1:0];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            raw_in = xmix_ff + y_ff + {1'b0, w_ff};
            if (bound_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (rem_stat.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Start the remainder unit in the cycle in which the raw sum register first holds the new sum.
   logic div_entry_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         div_entry_ff <= 1'b0;
      end else begin
         div_entry_ff <= (state_ff == ST_SUM) && (bound_ff != '0);
      end
   end

   tmjr_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_entry_ff),
      .dividend  (raw_ff),
      .divisor   (bound_ff),
      .stat      (rem_stat),
      .remainder (rem_value)
   );

   // Response register; it holds a beat until the consumer takes it.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_raw_in    = rsp_raw_ff;
      rsp_ranged_in = rsp_ranged_ff;
      rsp_bad_in    = rsp_bad_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_raw_in   = raw_ff;
         if (bound_ff == '0) begin
            rsp_ranged_in = '0;
            rsp_bad_in    = 1'b1;
         end else begin
            rsp_ranged_in = rem_value + 1'b1;
            rsp_bad_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         y_ff         <= SEED_Y;
         z_ff         <= SEED_Z;
         w_ff         <= SEED_W;
         c_ff         <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         y_ff         <= y_in;
         z_ff         <= z_in;
         w_ff         <= w_in;
         c_ff         <= c_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      xmix_ff       <= xmix_in;
      bound_ff      <= bound_in;
      raw_ff        <= raw_in;
      rsp_raw_ff    <= rsp_raw_in;
      rsp_ranged_ff <= rsp_ranged_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_raw_value    = rsp_raw_ff;
   assign rsp_ranged_value = rsp_ranged_ff;
   assign rsp_bad_bound    = rsp_bad_ff;

   // The remainder unit only runs while the sequencer waits on it.
   a_rem_busy_in_divide: assert property (@(posedge clock) disable iff (reset)
      rem_stat.busy |-> (state_ff == ST_DIVIDE))
      else $error("remainder unit busy outside the divide state");

   // Its completion pulse is only seen in the divide state.
   a_rem_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      rem_stat.done |-> (state_ff == ST_DIVIDE))
      else $error("remainder done outside the divide state");

   // An accepted request always advances the generator next.
   a_req_to_step: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == ST_STEP))
      else $error("request beat did not start a generator step");

   // A zero bound always reports a zero ranged value.
   a_bad_bound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_bound) |-> (rsp_ranged_value == '0))
      else $error("bad bound with nonzero ranged value");

endmodule
